FILE: design/tile_pyramid_geometry_defines.svh
// Assertion helpers for the tile pyramid geometry block.
// Each macro expects clk and rst_n in scope.
`ifndef TILE_PYRAMID_GEOMETRY_DEFINES_SVH
`define TILE_PYRAMID_GEOMETRY_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TPG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tpg: assertion failed");
// next-cycle implication
`define TPG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tpg: assertion failed");
`else
`define TPG_ASSERT_IMP(lbl, ante, cons)
`define TPG_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: design/tpg_pkg.sv
`default_nettype none

package tpg_pkg;

  localparam int unsigned IMG_W     = 30;  // image sizes, coordinates, indices
  localparam int unsigned TILE_W    = 13;  // tile sizes
  localparam int unsigned LVL_W     = 5;
  localparam int unsigned LCNT_W    = 6;
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PROD_W    = IMG_W + TILE_W;
  localparam int unsigned SPAN_W    = TILE_W + (1 << LVL_W) - 1;
  localparam int unsigned DCNT_W    = $clog2(IMG_W);

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_REGION = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_COUNTS = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOCATE = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT  = 2'd3;

  typedef struct packed {
    logic              start;
    logic [IMG_W-1:0]  dividend;
    logic [TILE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [IMG_W-1:0]  quotient;
    logic [TILE_W-1:0] remainder;
  } div_rsp_t;

  typedef struct packed {
    logic [IMG_W-1:0]  src_x;
    logic [IMG_W-1:0]  src_y;
    logic [IMG_W-1:0]  src_w;
    logic [IMG_W-1:0]  src_h;
    logic [TILE_W-1:0] dst_w;
    logic [TILE_W-1:0] dst_h;
    logic [IMG_W-1:0]  tiles_across;
    logic [IMG_W-1:0]  tiles_down;
    logic [LCNT_W-1:0] level_count;
    logic [IMG_W-1:0]  found_column;
    logic [IMG_W-1:0]  found_row;
    logic              status;
  } res_t;

endpackage

`default_nettype wire

FILE: design/tile_pyramid_geometry.sv
// Tile pyramid geometry: address arithmetic for a tiled image pyramid. Program the image
// size and tile size through the cfg port while the block is idle (a size of 0 acts as 1),
// then send one request item per operation: func 0 returns a tile's full resolution
// rectangle and its clipped output size at a level (status 1 and zero sizes when the tile
// lies outside the level), func 1 returns the tile counts at a level and the number of
// pyramid levels, func 2 returns the tile holding a full resolution point, func 3 returns
// status 1. Fields an operation does not produce read 0. One request is worked on at a
// time and in_ready is low meanwhile; the finished result sits in an output register, so
// the next request is taken while it waits. Func 0 runs one 30x13 multiply plus a check
// and a clip step per axis; func 1 and func 2 wait on the shared restoring divider, which
// runs one 30 step division per axis (the level count search runs next to the first
// division and ends sooner); func 3 needs no compute step.
`default_nettype none
`include "tile_pyramid_geometry_defines.svh"

module tile_pyramid_geometry (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [tpg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tpg_pkg::IMG_W-1:0]     cfg_wdata,
  // request
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [tpg_pkg::FUNC_W-1:0]    in_func,
  input  wire logic [tpg_pkg::LVL_W-1:0]     in_level,
  input  wire logic [tpg_pkg::IMG_W-1:0]     in_tile_column,
  input  wire logic [tpg_pkg::IMG_W-1:0]     in_tile_row,
  input  wire logic [tpg_pkg::IMG_W-1:0]     in_source_x,
  input  wire logic [tpg_pkg::IMG_W-1:0]     in_source_y,
  // result
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [tpg_pkg::IMG_W-1:0]          out_src_x,
  output logic [tpg_pkg::IMG_W-1:0]          out_src_y,
  output logic [tpg_pkg::IMG_W-1:0]          out_src_w,
  output logic [tpg_pkg::IMG_W-1:0]          out_src_h,
  output logic [tpg_pkg::TILE_W-1:0]         out_dst_w,
  output logic [tpg_pkg::TILE_W-1:0]         out_dst_h,
  output logic [tpg_pkg::IMG_W-1:0]          out_tiles_across,
  output logic [tpg_pkg::IMG_W-1:0]          out_tiles_down,
  output logic [tpg_pkg::LCNT_W-1:0]         out_level_count,
  output logic [tpg_pkg::IMG_W-1:0]          out_found_column,
  output logic [tpg_pkg::IMG_W-1:0]          out_found_row,
  output logic                               out_status
);

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,  // region: index times tile size
    S_CHK  = 6'b000100,  // region: bounds check, left/top edge
    S_CLIP = 6'b001000,  // region: clipped source and output extents
    S_DIV  = 6'b010000,  // counts/locate: divider running
    S_DONE = 6'b100000   // wait for output register and level search
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [tpg_pkg::IMG_W-1:0]  iw_r, ih_r;
  logic [tpg_pkg::TILE_W-1:0] tw_r, th_r;

  // effective sizes, zero reads as one
  logic [tpg_pkg::IMG_W-1:0]  iw_e, ih_e;
  logic [tpg_pkg::TILE_W-1:0] tw_e, th_e;

  // latched request
  logic [tpg_pkg::FUNC_W-1:0] func_r;
  logic [tpg_pkg::LVL_W-1:0]  level_r;
  logic [tpg_pkg::IMG_W-1:0]  col_r, row_r, sx_r, sy_r;

  logic accept;
  logic axis_r;  // 0 = x/width, 1 = y/height

  // level sizes
  logic [tpg_pkg::IMG_W-1:0] lvw_sh, lvh_sh, lvl_w, lvl_h;

  // per-axis selection
  logic [tpg_pkg::IMG_W-1:0]  ax_idx, ax_lvl, ax_img, ax_src;
  logic [tpg_pkg::TILE_W-1:0] ax_tile;

  // region datapath
  logic [tpg_pkg::PROD_W-1:0] prod_r;
  logic                       ax_ok;
  logic [tpg_pkg::IMG_W-1:0]  ax_pos, ax_rest, ax_slen, ax_drest;
  logic [tpg_pkg::SPAN_W-1:0] ax_span;
  logic [tpg_pkg::TILE_W-1:0] ax_dlen;
  logic                       ok_r   [2];
  logic [tpg_pkg::IMG_W-1:0]  pos_r  [2];
  logic [tpg_pkg::IMG_W-1:0]  slen_r [2];
  logic [tpg_pkg::TILE_W-1:0] dlen_r [2];

  // division results per axis
  logic [tpg_pkg::IMG_W-1:0] res_r [2];
  logic [tpg_pkg::IMG_W-1:0] div_val;
  logic                      div_go_r;
  tpg_pkg::div_req_t         div_req;
  tpg_pkg::div_rsp_t         div_rsp;

  // level count search
  logic                      lc_busy_r;
  logic                      lc_more;
  logic [tpg_pkg::IMG_W-1:0] lw_r, lh_r, lw_half, lh_half;
  logic [tpg_pkg::LCNT_W-1:0] lcnt_r;

  // output register
  logic          out_valid_r;
  logic          out_free;
  logic          load_out;
  tpg_pkg::res_t out_res_r, out_res_nxt;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iw_r <= tpg_pkg::IMG_W'(1);
      ih_r <= tpg_pkg::IMG_W'(1);
      tw_r <= tpg_pkg::TILE_W'(256);
      th_r <= tpg_pkg::TILE_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        tpg_pkg::CFG_IMAGE_WIDTH:  iw_r <= cfg_wdata;
        tpg_pkg::CFG_IMAGE_HEIGHT: ih_r <= cfg_wdata;
        tpg_pkg::CFG_TILE_WIDTH:   tw_r <= cfg_wdata[tpg_pkg::TILE_W-1:0];
        tpg_pkg::CFG_TILE_HEIGHT:  th_r <= cfg_wdata[tpg_pkg::TILE_W-1:0];
      endcase
    end
  end

  assign iw_e = (iw_r == '0) ? tpg_pkg::IMG_W'(1) : iw_r;
  assign ih_e = (ih_r == '0) ? tpg_pkg::IMG_W'(1) : ih_r;
  assign tw_e = (tw_r == '0) ? tpg_pkg::TILE_W'(1) : tw_r;
  assign th_e = (th_r == '0) ? tpg_pkg::TILE_W'(1) : th_r;

  // level size: halved per level, floor of one
  assign lvw_sh = iw_e >> level_r;
  assign lvh_sh = ih_e >> level_r;
  assign lvl_w  = (lvw_sh == '0) ? tpg_pkg::IMG_W'(1) : lvw_sh;
  assign lvl_h  = (lvh_sh == '0) ? tpg_pkg::IMG_W'(1) : lvh_sh;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign ax_idx  = axis_r ? row_r : col_r;
  assign ax_tile = axis_r ? th_e  : tw_e;
  assign ax_lvl  = axis_r ? lvl_h : lvl_w;
  assign ax_img  = axis_r ? ih_e  : iw_e;
  assign ax_src  = axis_r ? sy_r  : sx_r;

  // ---------------------------------------------------------------------------
  // Region datapath. Tile is inside iff idx*tile < level size; then the left edge
  // (idx*tile) << level is below the image size and fits 30 bits.
  // ---------------------------------------------------------------------------
  assign ax_ok   = prod_r < tpg_pkg::PROD_W'(ax_lvl);
  assign ax_pos  = prod_r[tpg_pkg::IMG_W-1:0] << level_r;

  assign ax_rest  = ax_img - pos_r[axis_r];
  assign ax_span  = tpg_pkg::SPAN_W'(ax_tile) << level_r;
  assign ax_slen  = (ax_span < tpg_pkg::SPAN_W'(ax_rest))
                    ? ax_span[tpg_pkg::IMG_W-1:0] : ax_rest;
  assign ax_drest = ax_lvl - prod_r[tpg_pkg::IMG_W-1:0];
  assign ax_dlen  = (tpg_pkg::IMG_W'(ax_tile) < ax_drest)
                    ? ax_tile : ax_drest[tpg_pkg::TILE_W-1:0];

  // ---------------------------------------------------------------------------
  // Shared divider. Counts: ceil(level size / tile). Locate: floor((src >> level) / tile),
  // which equals floor(src / (tile << level)).
  // ---------------------------------------------------------------------------
  assign div_req.start    = div_go_r;
  assign div_req.dividend = (func_r == tpg_pkg::FUNC_COUNTS) ? ax_lvl : (ax_src >> level_r);
  assign div_req.divisor  = ax_tile;

  tpg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // round up on a nonzero remainder; only possible for tile >= 2, so no overflow
  assign div_val = div_rsp.quotient
                 + tpg_pkg::IMG_W'((func_r == tpg_pkg::FUNC_COUNTS) &&
                                   (div_rsp.remainder != '0));

  // ---------------------------------------------------------------------------
  // Level count: halve both sizes until each fits in one tile.
  // ceil(w / tw) > 1 is the same as w > tw.
  // ---------------------------------------------------------------------------
  assign lc_more = (lw_r > tpg_pkg::IMG_W'(tw_e)) || (lh_r > tpg_pkg::IMG_W'(th_e));
  assign lw_half = (lw_r[tpg_pkg::IMG_W-1:1] == '0) ? tpg_pkg::IMG_W'(1) : (lw_r >> 1);
  assign lh_half = (lh_r[tpg_pkg::IMG_W-1:1] == '0) ? tpg_pkg::IMG_W'(1) : (lh_r >> 1);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign out_free = !out_valid_r || out_ready;
  assign load_out = (state_r == S_DONE) && out_free && !lc_busy_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          priority if (in_func == tpg_pkg::FUNC_REGION) begin
            state_nxt = S_MUL;
          end else if (in_func == tpg_pkg::FUNC_COUNTS || in_func == tpg_pkg::FUNC_LOCATE) begin
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_MUL:  state_nxt = S_CHK;
      S_CHK:  state_nxt = S_CLIP;
      S_CLIP: state_nxt = axis_r ? S_DONE : S_MUL;
      S_DIV: begin
        if (div_rsp.done && axis_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= 1'b0;
      div_go_r    <= 1'b0;
      lc_busy_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      div_go_r <= (accept && (in_func == tpg_pkg::FUNC_COUNTS ||
                              in_func == tpg_pkg::FUNC_LOCATE))
               || ((state_r == S_DIV) && div_rsp.done && !axis_r);

      if (accept) begin
        axis_r <= 1'b0;
      end else if ((state_r == S_CLIP) || ((state_r == S_DIV) && div_rsp.done)) begin
        axis_r <= 1'b1;
      end

      if (accept && (in_func == tpg_pkg::FUNC_COUNTS)) begin
        lc_busy_r <= 1'b1;
      end else if (lc_busy_r && !lc_more) begin
        lc_busy_r <= 1'b0;
      end

      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r  <= in_func;
      level_r <= in_level;
      col_r   <= in_tile_column;
      row_r   <= in_tile_row;
      sx_r    <= in_source_x;
      sy_r    <= in_source_y;
      lw_r    <= iw_e;
      lh_r    <= ih_e;
      lcnt_r  <= tpg_pkg::LCNT_W'(1);
    end else if (lc_busy_r && lc_more) begin
      lw_r   <= lw_half;
      lh_r   <= lh_half;
      lcnt_r <= lcnt_r + 1'b1;
    end

    if (state_r == S_MUL) begin
      prod_r <= tpg_pkg::PROD_W'(ax_idx) * tpg_pkg::PROD_W'(ax_tile);
    end
    if (state_r == S_CHK) begin
      ok_r[axis_r]  <= ax_ok;
      pos_r[axis_r] <= ax_pos;
    end
    if (state_r == S_CLIP) begin
      slen_r[axis_r] <= ax_slen;
      dlen_r[axis_r] <= ax_dlen;
    end
    if ((state_r == S_DIV) && div_rsp.done) begin
      res_r[axis_r] <= div_val;
    end
    if (load_out) begin
      out_res_r <= out_res_nxt;
    end
  end

  // result assembly: fields of other operations stay zero
  always_comb begin
    out_res_nxt = '0;
    unique case (func_r)
      tpg_pkg::FUNC_REGION: begin
        if (ok_r[0] && ok_r[1]) begin
          out_res_nxt.src_x = pos_r[0];
          out_res_nxt.src_y = pos_r[1];
          out_res_nxt.src_w = slen_r[0];
          out_res_nxt.src_h = slen_r[1];
          out_res_nxt.dst_w = dlen_r[0];
          out_res_nxt.dst_h = dlen_r[1];
        end else begin
          out_res_nxt.status = 1'b1;
        end
      end
      tpg_pkg::FUNC_COUNTS: begin
        out_res_nxt.tiles_across = res_r[0];
        out_res_nxt.tiles_down   = res_r[1];
        out_res_nxt.level_count  = lcnt_r;
      end
      tpg_pkg::FUNC_LOCATE: begin
        out_res_nxt.found_column = res_r[0];
        out_res_nxt.found_row    = res_r[1];
      end
      default: out_res_nxt.status = 1'b1;  // unused selector
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_src_x        = out_res_r.src_x;
  assign out_src_y        = out_res_r.src_y;
  assign out_src_w        = out_res_r.src_w;
  assign out_src_h        = out_res_r.src_h;
  assign out_dst_w        = out_res_r.dst_w;
  assign out_dst_h        = out_res_r.dst_h;
  assign out_tiles_across = out_res_r.tiles_across;
  assign out_tiles_down   = out_res_r.tiles_down;
  assign out_level_count  = out_res_r.level_count;
  assign out_found_column = out_res_r.found_column;
  assign out_found_row    = out_res_r.found_row;
  assign out_status       = out_res_r.status;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `TPG_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `TPG_ASSERT_IMP(a_div_done_in_div, div_rsp.done, state_r == S_DIV)
  `TPG_ASSERT_IMP(a_idle_units_quiet, state_r == S_IDLE, !div_rsp.busy && !lc_busy_r)
  `TPG_ASSERT_IMP(a_error_zero_sizes, out_valid && out_status, out_src_w == '0 && out_dst_w == '0 && out_dst_h == '0)

endmodule

`default_nettype wire

FILE: design/tpg_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle, MSB first.
// Divisor must stay stable while busy.
module tpg_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tpg_pkg::div_req_t req,
  output tpg_pkg::div_rsp_t      rsp
);

  logic                             busy_r;
  logic                             done_r;
  logic [tpg_pkg::DCNT_W-1:0]       cnt_r;
  logic [tpg_pkg::IMG_W-1:0]        quo_r;   // dividend shifts out, quotient shifts in
  logic [tpg_pkg::TILE_W-1:0]       rem_r;
  logic [tpg_pkg::TILE_W:0]         rem_sh;
  logic [tpg_pkg::TILE_W:0]         rem_diff;
  logic                             fits;
  logic [tpg_pkg::TILE_W-1:0]       rem_nxt;

  assign rem_sh   = {rem_r, quo_r[tpg_pkg::IMG_W-1]};
  assign rem_diff = rem_sh - {1'b0, req.divisor};
  assign fits     = rem_sh >= {1'b0, req.divisor};
  assign rem_nxt  = fits ? rem_diff[tpg_pkg::TILE_W-1:0] : rem_sh[tpg_pkg::TILE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= tpg_pkg::DCNT_W'(tpg_pkg::IMG_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[tpg_pkg::IMG_W-2:0], fits};
      rem_r <= rem_nxt;
    end
  end

  assign rsp.busy      = busy_r;
  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

`default_nettype wire

FILE: bench/tb_tile_pyramid_geometry.sv
`timescale 1ns / 1ps

// Testbench for the tile pyramid geometry block.
// A predictor inside the bench computes the result of each request from its own copy of
// the four size registers. Requests go in through a valid/ready sender with random gaps,
// results come back through a receiver with random stalls, and every accepted result is
// compared field by field against the oldest prediction waiting in the queue.

module tb_tile_pyramid_geometry;

  localparam int unsigned IMG_W     = tpg_pkg::IMG_W;
  localparam int unsigned TILE_W    = tpg_pkg::TILE_W;
  localparam int unsigned LVL_W     = tpg_pkg::LVL_W;
  localparam int unsigned LCNT_W    = tpg_pkg::LCNT_W;
  localparam int unsigned FUNC_W    = tpg_pkg::FUNC_W;
  localparam int unsigned CFG_IDX_W = tpg_pkg::CFG_IDX_W;

  localparam logic [FUNC_W-1:0] FUNC_REGION = tpg_pkg::FUNC_REGION;
  localparam logic [FUNC_W-1:0] FUNC_COUNTS = tpg_pkg::FUNC_COUNTS;
  localparam logic [FUNC_W-1:0] FUNC_LOCATE = tpg_pkg::FUNC_LOCATE;

  typedef tpg_pkg::res_t res_t;

  // the one selector value that has no operation behind it
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic [IMG_W-1:0]  MAX30       = 30'h3FFFFFFF;

  logic clk = 1'b0;
  logic rst_n;

  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [IMG_W-1:0]     cfg_wdata;

  logic              in_valid;
  logic              in_ready;
  logic [FUNC_W-1:0] in_func;
  logic [LVL_W-1:0]  in_level;
  logic [IMG_W-1:0]  in_tile_column;
  logic [IMG_W-1:0]  in_tile_row;
  logic [IMG_W-1:0]  in_source_x;
  logic [IMG_W-1:0]  in_source_y;

  logic              out_valid;
  logic              out_ready;
  logic [IMG_W-1:0]  out_src_x;
  logic [IMG_W-1:0]  out_src_y;
  logic [IMG_W-1:0]  out_src_w;
  logic [IMG_W-1:0]  out_src_h;
  logic [TILE_W-1:0] out_dst_w;
  logic [TILE_W-1:0] out_dst_h;
  logic [IMG_W-1:0]  out_tiles_across;
  logic [IMG_W-1:0]  out_tiles_down;
  logic [LCNT_W-1:0] out_level_count;
  logic [IMG_W-1:0]  out_found_column;
  logic [IMG_W-1:0]  out_found_row;
  logic              out_status;

  // bench copy of the size registers, as the block holds them
  logic [IMG_W-1:0]  img_w_cfg;
  logic [IMG_W-1:0]  img_h_cfg;
  logic [TILE_W-1:0] tile_w_cfg;
  logic [TILE_W-1:0] tile_h_cfg;

  // predicted results, oldest first
  res_t geometry_q[$];

  bit gaps_on  = 1'b1;  // random idling on both sides
  int hold_len = 0;     // long receiver hold-off, picked up by the receiver process

  int mismatches      = 0;
  int results_checked = 0;
  int setups_written  = 0;
  int func_seen[4]    = '{0, 0, 0, 0};

  tile_pyramid_geometry dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_level         (in_level),
    .in_tile_column   (in_tile_column),
    .in_tile_row      (in_tile_row),
    .in_source_x      (in_source_x),
    .in_source_y      (in_source_y),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_src_x        (out_src_x),
    .out_src_y        (out_src_y),
    .out_src_w        (out_src_w),
    .out_src_h        (out_src_h),
    .out_dst_w        (out_dst_w),
    .out_dst_h        (out_dst_h),
    .out_tiles_across (out_tiles_across),
    .out_tiles_down   (out_tiles_down),
    .out_level_count  (out_level_count),
    .out_found_column (out_found_column),
    .out_found_row    (out_found_row),
    .out_status       (out_status)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------------------
  // Geometry predictor. All math in 64 bits, so spans up to 8191 << 31 stay exact.
  // ---------------------------------------------------------------------------------------

  // a size register holding 0 acts as 1
  function automatic logic [63:0] nz(input logic [63:0] v);
    return (v == 0) ? 64'd1 : v;
  endfunction

  // image extent at a level: halved per level, never below 1
  function automatic logic [63:0] lvl_extent(input logic [63:0] full, input int unsigned lv);
    logic [63:0] s;
    s = nz(full) >> lv;
    return (s == 0) ? 64'd1 : s;
  endfunction

  function automatic logic [63:0] ceil_quot(input logic [63:0] a, input logic [63:0] b);
    return (a + b - 1) / b;
  endfunction

  // one axis of a region request; returns 0 when the tile index lies past the level
  function automatic bit clip_axis(input logic [63:0] full, input logic [63:0] tile,
                                   input int unsigned lv, input logic [63:0] idx,
                                   output logic [63:0] pos, output logic [63:0] src_len,
                                   output logic [63:0] dst_len);
    logic [63:0] img, ext, span, rest;
    img     = nz(full);
    ext     = lvl_extent(full, lv);
    pos     = 0;
    src_len = 0;
    dst_len = 0;
    if (idx >= ceil_quot(ext, tile)) return 1'b0;
    span    = tile << lv;
    pos     = idx * span;
    rest    = img - pos;
    src_len = (span < rest) ? span : rest;
    rest    = ext - idx * tile;
    dst_len = (tile < rest) ? tile : rest;
    return 1'b1;
  endfunction

  // levels until one tile covers the whole level in both directions
  function automatic logic [63:0] pyramid_depth();
    logic [63:0] w, h, tw, th, n;
    w  = nz(img_w_cfg);
    h  = nz(img_h_cfg);
    tw = nz(tile_w_cfg);
    th = nz(tile_h_cfg);
    n  = 1;
    while (ceil_quot(w, tw) > 1 || ceil_quot(h, th) > 1) begin
      w = w >> 1;
      if (w == 0) w = 1;
      h = h >> 1;
      if (h == 0) h = 1;
      n++;
    end
    return n;
  endfunction

  function automatic res_t predict_geometry(input logic [FUNC_W-1:0] f,
                                            input logic [LVL_W-1:0] lv,
                                            input logic [IMG_W-1:0] col,
                                            input logic [IMG_W-1:0] row,
                                            input logic [IMG_W-1:0] sx,
                                            input logic [IMG_W-1:0] sy);
    res_t        r;
    logic [63:0] tw, th, x, y, sw, sh, dw, dh, q;
    bit          okx, oky;
    r  = '0;
    tw = nz(tile_w_cfg);
    th = nz(tile_h_cfg);
    case (f)
      FUNC_REGION: begin
        okx = clip_axis(img_w_cfg, tw, lv, col, x, sw, dw);
        oky = clip_axis(img_h_cfg, th, lv, row, y, sh, dh);
        if (okx && oky) begin
          r.src_x = x[IMG_W-1:0];
          r.src_y = y[IMG_W-1:0];
          r.src_w = sw[IMG_W-1:0];
          r.src_h = sh[IMG_W-1:0];
          r.dst_w = dw[TILE_W-1:0];
          r.dst_h = dh[TILE_W-1:0];
        end else begin
          r.status = 1'b1;
        end
      end
      FUNC_COUNTS: begin
        q = ceil_quot(lvl_extent(img_w_cfg, lv), tw);
        r.tiles_across = q[IMG_W-1:0];
        q = ceil_quot(lvl_extent(img_h_cfg, lv), th);
        r.tiles_down = q[IMG_W-1:0];
        q = pyramid_depth();
        r.level_count = q[LCNT_W-1:0];
      end
      FUNC_LOCATE: begin
        // no range check: a point past the image still gives status 0
        q = 64'(sx) / (tw << lv);
        r.found_column = q[IMG_W-1:0];
        q = 64'(sy) / (th << lv);
        r.found_row = q[IMG_W-1:0];
      end
      default: r.status = 1'b1;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t MISMATCH %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // outputs sampled at the rising edge, before the block updates them
  always @(posedge clk) begin : check_results
    res_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_src_x, out_src_y, out_src_w, out_src_h, out_dst_w, out_dst_h,
             out_tiles_across, out_tiles_down, out_level_count,
             out_found_column, out_found_row, out_status};
      if (geometry_q.size() == 0) begin
        report_mismatch("result with no request pending", 64'(got.status), 64'd0);
      end else begin
        want = geometry_q.pop_front();
        results_checked++;
        check_field("src_x", got.src_x, want.src_x);
        check_field("src_y", got.src_y, want.src_y);
        check_field("src_w", got.src_w, want.src_w);
        check_field("src_h", got.src_h, want.src_h);
        check_field("dst_w", got.dst_w, want.dst_w);
        check_field("dst_h", got.dst_h, want.dst_h);
        check_field("tiles_across", got.tiles_across, want.tiles_across);
        check_field("tiles_down", got.tiles_down, want.tiles_down);
        check_field("level_count", got.level_count, want.level_count);
        check_field("found_column", got.found_column, want.found_column);
        check_field("found_row", got.found_row, want.found_row);
        check_field("status", got.status, want.status);
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Result receiver: random stall bursts, plus a long hold-off when one is requested.
  // ---------------------------------------------------------------------------------------
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        out_ready = 1'b0;
        repeat (hold_len) @(negedge clk);
        hold_len  = 0;
        out_ready = 1'b1;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        out_ready = 1'b1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers. All of them start and end on a falling edge.
  // ---------------------------------------------------------------------------------------

  // one register write, taken at the next rising edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [IMG_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
  endtask

  // write all four size registers; only called with nothing in flight
  task automatic program_geometry(input logic [IMG_W-1:0] iw, input logic [IMG_W-1:0] ih,
                                  input logic [IMG_W-1:0] tw, input logic [IMG_W-1:0] th);
    write_reg(tpg_pkg::CFG_IMAGE_WIDTH, iw);
    write_reg(tpg_pkg::CFG_IMAGE_HEIGHT, ih);
    write_reg(tpg_pkg::CFG_TILE_WIDTH, tw);
    write_reg(tpg_pkg::CFG_TILE_HEIGHT, th);
    cfg_we     = 1'b0;
    img_w_cfg  = iw;
    img_h_cfg  = ih;
    tile_w_cfg = tw[TILE_W-1:0];  // tile registers keep the low 13 bits
    tile_h_cfg = th[TILE_W-1:0];
    setups_written++;
  endtask

  // offer one item, wait for the handshake, log the prediction
  task automatic send_request(input logic [FUNC_W-1:0] f, input logic [LVL_W-1:0] lv,
                              input logic [IMG_W-1:0] col, input logic [IMG_W-1:0] row,
                              input logic [IMG_W-1:0] sx, input logic [IMG_W-1:0] sy);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_func        = f;
    in_level       = lv;
    in_tile_column = col;
    in_tile_row    = row;
    in_source_x    = sx;
    in_source_y    = sy;
    in_valid       = 1'b1;
    do @(posedge clk); while (!in_ready);
    geometry_q.insert(geometry_q.size(), predict_geometry(f, lv, col, row, sx, sy));
    func_seen[f]++;
    @(negedge clk);
  endtask

  // drop valid and wait until every predicted result has been checked
  task automatic settle_block();
    in_valid = 1'b0;
    while (geometry_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [IMG_W-1:0] rand30();
    return IMG_W'($urandom);
  endfunction

  function automatic logic [IMG_W-1:0] pick_image_size();
    logic [IMG_W-1:0] v;
    case ($urandom_range(0, 6))
      0: v = IMG_W'($urandom_range(1, 64));
      1: v = IMG_W'($urandom_range(1, 5000));
      2: v = rand30();
      3: v = (IMG_W'(1) << $urandom_range(0, 29)) + IMG_W'($urandom_range(0, 2)) - 1'b1;
      4: v = MAX30;
      5: v = IMG_W'($urandom_range(0, 1));  // zero acts as one
      default: v = IMG_W'($urandom_range(1, 100000));
    endcase
    return v;
  endfunction

  // write data for a tile register, sometimes with junk above bit 12
  function automatic logic [IMG_W-1:0] pick_tile_size();
    logic [IMG_W-1:0] v;
    case ($urandom_range(0, 9))
      5: v = IMG_W'($urandom_range(1, 16));
      6: v = '0;
      7: v = IMG_W'($urandom_range(4097, 8191));  // above range, used as written
      8: v = (rand30() << TILE_W) | IMG_W'($urandom_range(1, 4096));
      9: v = IMG_W'(4096);
      default: v = IMG_W'($urandom_range(1, 4096));
    endcase
    return v;
  endfunction

  // mostly well-formed requests aimed inside the current pyramid, some junk
  task automatic random_request();
    logic [FUNC_W-1:0] f;
    logic [LVL_W-1:0]  lv;
    logic [IMG_W-1:0]  col, row, sx, sy;
    logic [63:0]       across, down, depth;
    int unsigned       sel;
    sel   = $urandom_range(0, 99);
    f     = (sel < 40) ? FUNC_REGION : (sel < 65) ? FUNC_COUNTS :
            (sel < 95) ? FUNC_LOCATE : FUNC_UNUSED;
    depth = pyramid_depth();
    if (depth > 32) depth = 32;
    lv    = ($urandom_range(0, 4) != 0) ? LVL_W'($urandom_range(0, int'(depth) - 1))
                                        : LVL_W'($urandom);
    col   = rand30();
    row   = rand30();
    sx    = rand30();
    sy    = rand30();
    if (f == FUNC_REGION) begin
      across = ceil_quot(lvl_extent(img_w_cfg, lv), nz(tile_w_cfg));
      down   = ceil_quot(lvl_extent(img_h_cfg, lv), nz(tile_h_cfg));
      sel    = $urandom_range(0, 19);
      if (sel < 15) col = IMG_W'($urandom_range(0, int'(across) - 1));
      else if (sel < 17 && across <= MAX30) col = IMG_W'(across);  // just past the edge
      sel    = $urandom_range(0, 19);
      if (sel < 15) row = IMG_W'($urandom_range(0, int'(down) - 1));
      else if (sel < 17 && down <= MAX30) row = IMG_W'(down);
    end else if (f == FUNC_LOCATE) begin
      if ($urandom_range(0, 9) < 7) sx = IMG_W'($urandom_range(0, int'(nz(img_w_cfg)) - 1));
      if ($urandom_range(0, 9) < 7) sy = IMG_W'($urandom_range(0, int'(nz(img_h_cfg)) - 1));
    end
    send_request(f, lv, col, row, sx, sy);
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // register values straight out of reset: 1x1 image, 256x256 tiles
  task automatic test_reset_values();
    send_request(FUNC_REGION, 5'd0, 30'd0, 30'd0, 30'd0, 30'd0);
    send_request(FUNC_REGION, 5'd0, 30'd1, 30'd0, MAX30, MAX30);  // column past level
    send_request(FUNC_COUNTS, 5'd0, MAX30, MAX30, MAX30, MAX30);
    send_request(FUNC_LOCATE, 5'd0, 30'd0, 30'd0, MAX30, MAX30);
    send_request(FUNC_UNUSED, 5'd31, MAX30, MAX30, MAX30, MAX30);
    settle_block();
  endtask

  // largest image with one pixel tiles: deepest pyramid, biggest counts
  task automatic test_extreme_sizes();
    program_geometry(MAX30, MAX30, 30'd1, 30'd1);
    send_request(FUNC_REGION, 5'd0, MAX30 - 1'b1, 30'd0, 30'd0, 30'd0);
    send_request(FUNC_REGION, 5'd0, MAX30, 30'd0, 30'd0, 30'd0);  // one past the last
    send_request(FUNC_REGION, 5'd31, 30'd0, 30'd0, MAX30, MAX30);
    send_request(FUNC_COUNTS, 5'd0, 30'd0, 30'd0, 30'd0, 30'd0);
    send_request(FUNC_COUNTS, 5'd31, 30'd0, 30'd0, 30'd0, 30'd0);
    send_request(FUNC_LOCATE, 5'd31, 30'd0, 30'd0, MAX30, MAX30);
    send_request(FUNC_LOCATE, 5'd0, 30'd0, 30'd0, MAX30, MAX30);
    settle_block();
  endtask

  // tile sizes above 4096, junk above bit 12, and all-zero registers
  task automatic test_degenerate_registers();
    logic [63:0] last_col, last_row;
    program_geometry(MAX30, MAX30, 30'd8191, 30'h3FFFF000);  // height keeps 4096
    last_col = ceil_quot(lvl_extent(img_w_cfg, 0), nz(tile_w_cfg)) - 1;
    last_row = ceil_quot(lvl_extent(img_h_cfg, 0), nz(tile_h_cfg)) - 1;
    send_request(FUNC_REGION, 5'd0, IMG_W'(last_col), IMG_W'(last_row), 30'd0, 30'd0);
    send_request(FUNC_COUNTS, 5'd5, 30'd0, 30'd0, 30'd0, 30'd0);
    send_request(FUNC_LOCATE, 5'd3, 30'd0, 30'd0, MAX30, MAX30);
    settle_block();
    // every register zero: all of them act as 1
    program_geometry(30'd0, 30'd0, 30'd0, 30'd0);
    send_request(FUNC_REGION, 5'd0, 30'd0, 30'd0, MAX30, MAX30);
    send_request(FUNC_REGION, 5'd0, 30'd1, 30'd0, 30'd0, 30'd0);
    send_request(FUNC_COUNTS, 5'd0, 30'd0, 30'd0, 30'd0, 30'd0);
    send_request(FUNC_LOCATE, 5'd31, 30'd0, 30'd0, MAX30, MAX30);
    send_request(FUNC_REGION, 5'd31, 30'd0, 30'd0, rand30(), rand30());
    settle_block();
  endtask

  // image just past one tile: edge tiles get clipped on both sides
  task automatic test_edge_clipping();
    program_geometry(30'd4097, 30'd3, 30'd4096, 30'd1);
    send_request(FUNC_REGION, 5'd0, 30'd1, 30'd2, 30'd0, 30'd0);
    send_request(FUNC_REGION, 5'd1, 30'd0, 30'd0, 30'd0, 30'd0);
    send_request(FUNC_COUNTS, 5'd1, 30'd0, 30'd0, 30'd0, 30'd0);
    send_request(FUNC_UNUSED, 5'd0, 30'd0, 30'd0, 30'd0, 30'd0);
    settle_block();
  endtask

  // receiver holds off for a long stretch while requests keep coming,
  // so the output register fills and in_ready has to drop
  task automatic test_backpressure();
    program_geometry(30'd1920, 30'd1080, 30'd256, 30'd256);
    gaps_on  = 1'b0;
    hold_len = 400;
    repeat (10) random_request();
    settle_block();
    gaps_on  = 1'b1;
  endtask

  // sender waits for a full drain halfway through
  task automatic test_drain_pause();
    repeat (5) random_request();
    in_valid = 1'b0;
    while (geometry_q.size() != 0) @(negedge clk);
    repeat (5) random_request();
    settle_block();
  endtask

  task automatic test_random_setups();
    for (int p = 0; p < 6; p++) begin
      program_geometry(pick_image_size(), pick_image_size(),
                       pick_tile_size(), pick_tile_size());
      repeat (180) random_request();
      settle_block();
    end
  endtask

  // last stretch: no idling on either side
  task automatic test_quiet_tail();
    gaps_on = 1'b0;
    program_geometry(pick_image_size(), pick_image_size(),
                     pick_tile_size(), pick_tile_size());
    repeat (120) random_request();
    settle_block();
  endtask

  // ---------------------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_func        = FUNC_REGION;
    in_level       = '0;
    in_tile_column = '0;
    in_tile_row    = '0;
    in_source_x    = '0;
    in_source_y    = '0;
    // register values after reset
    img_w_cfg      = 30'd1;
    img_h_cfg      = 30'd1;
    tile_w_cfg     = 13'd256;
    tile_h_cfg     = 13'd256;

    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_values();
    test_extreme_sizes();
    test_degenerate_registers();
    test_edge_clipping();
    test_backpressure();
    test_drain_pause();
    test_random_setups();
    test_quiet_tail();

    // give the longest operation room before calling it done
    repeat (100) @(negedge clk);

    $display("Ran %0d region, %0d count, %0d locate and %0d unused-selector requests",
             func_seen[FUNC_REGION], func_seen[FUNC_COUNTS], func_seen[FUNC_LOCATE],
             func_seen[FUNC_UNUSED]);
    $display("over %0d register setups; %0d results checked, %0d mismatches",
             setups_written, results_checked, mismatches);
    if (mismatches == 0 && geometry_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("Timeout with %0d results outstanding", geometry_q.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/tpg_pkg.sv
design/tpg_div.sv
design/tile_pyramid_geometry.sv
bench/tb_tile_pyramid_geometry.sv
